@@ hdl/lmstrn_pkg.sv @@
// shared types, constants and saturation helper for the lms linear layer trainer
// no dependencies
`timescale 1ns / 1ps
package lmstrn_pkg;
  localparam int MAX_INPUTS = 16;
  localparam int MAX_UNITS  = 4;
  localparam int ROW_LEN    = MAX_INPUTS + 1;
  localparam int DW         = 24;
  localparam int TAP_W      = 5;
  localparam int UNIT_W     = 2;
  localparam int XIDX_W     = $clog2(MAX_INPUTS);
  localparam int MU_W       = 16;
  localparam int ACC_W      = 52;
  localparam int CIDX_W     = 3;
  localparam int DRAIN_CYC  = MAX_UNITS + 6;
  localparam int DRN_W      = $clog2(DRAIN_CYC + 1);

  typedef enum logic [1:0] {
    KIND_INPUT  = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_WLOAD  = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_STEP   = 3'd0,
    CFG_BIAS   = 3'd1,
    CFG_NINP   = 3'd2,
    CFG_NUNITS = 3'd3,
    CFG_TRAIN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                 vld;
    logic                 upd;
    logic                 lst;
    logic [TAP_W-1:0]     tap;
    logic signed [DW-1:0] x;
  } tok_t;

  typedef struct packed {
    logic                 vld;
    logic [UNIT_W-1:0]    unit;
    logic [TAP_W-1:0]     tap;
    logic signed [DW-1:0] val;
  } wload_t;

  typedef struct packed {
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] e;
  } cell_res_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (v > hi) return DW'(hi);
    else if (v < lo) return DW'(lo);
    else return v[DW-1:0];
  endfunction
endpackage

@@ hdl/lmstrn_if.sv @@
// channel interfaces: sample input, unit result and register write
// depends on lmstrn_pkg
`timescale 1ns / 1ps
interface lmstrn_in_if;
  import lmstrn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic signed [DW-1:0] value;
  logic [UNIT_W-1:0]    unit;
  logic [TAP_W-1:0]     tap;
  modport source (output valid, kind, value, unit, tap, input ready);
  modport sink (input valid, kind, value, unit, tap, output ready);
endinterface

interface lmstrn_out_if;
  import lmstrn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [UNIT_W-1:0]    unit_index;
  logic signed [DW-1:0] unit_output;
  logic signed [DW-1:0] unit_error;
  logic                 last;
  modport source (output valid, unit_index, unit_output, unit_error, last, input ready);
  modport sink (input valid, unit_index, unit_output, unit_error, last, output ready);
endinterface

interface lmstrn_cfg_if;
  import lmstrn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [DW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/lmstrn_cell.sv @@
// one output unit: weight row, multiply-accumulate and lms update pipeline
// passes the tap token to the next cell each cycle; depends on lmstrn_pkg
`timescale 1ns / 1ps
module lmstrn_cell
  import lmstrn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [UNIT_W-1:0]    cell_idx,
  input  logic                 en,
  input  logic [MU_W-1:0]      mu,
  input  logic signed [DW-1:0] tgt,
  input  wload_t               wl,
  input  tok_t                 tok_i,
  output tok_t                 tok_o,
  output cell_res_t            res_o
);
  tok_t                    tok_r;
  logic signed [DW-1:0]    w_r [ROW_LEN];
  logic                    s1_vld_r, s1_upd_r, s1_lst_r, s1_first_r;
  logic [TAP_W-1:0]        s1_tap_r;
  logic signed [DW-1:0]    s1_w_r;
  logic signed [2*DW-1:0]  s1_prod_r;
  logic                    s2_upd_r;
  logic [TAP_W-1:0]        s2_tap_r;
  logic signed [DW-1:0]    s2_w_r;
  logic signed [40:0]      pp_hi_r;
  logic [39:0]             pp_lo_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    fin_r, fin2_r;
  logic signed [DW-1:0]    y_r, e_r;
  logic signed [DW-1:0]    mul_b;
  logic signed [DW-1:0]    w_rd;
  logic signed [64:0]      upd_sum;
  logic signed [64:0]      upd_rnd;
  logic signed [31:0]      upd_term;
  logic signed [DW-1:0]    w_new;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [31:0]      y_sh;
  logic signed [DW-1:0]    y_sat;

  assign tok_o = tok_r;
  assign res_o = '{y: y_r, e: e_r};
  assign w_rd  = w_r[tok_r.tap];
  assign mul_b = tok_r.upd ? e_r : w_rd;

  assign acc_nxt = s1_first_r ? ACC_W'(s1_prod_r) : acc_r + ACC_W'(s1_prod_r);
  assign acc_rnd = acc_r + ACC_W'(64'sd524288);
  assign y_sh    = 32'(acc_rnd >>> 20);
  assign y_sat   = sat32(y_sh);

  assign upd_sum  = (65'(pp_hi_r) <<< 24) + $signed({25'd0, pp_lo_r});
  assign upd_rnd  = upd_sum + 65'sd17179869184;
  assign upd_term = 32'(upd_rnd >>> 35);
  assign w_new    = sat32(32'(s2_w_r) + upd_term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_upd_r <= 1'b0;
      fin_r    <= 1'b0;
      fin2_r   <= 1'b0;
      for (int i = 0; i < ROW_LEN; i++) w_r[i] <= '0;
    end else begin
      tok_r      <= tok_i;
      s1_vld_r   <= tok_r.vld;
      s1_upd_r   <= tok_r.upd;
      s1_lst_r   <= tok_r.lst;
      s1_first_r <= (tok_r.tap == '0);
      s1_tap_r   <= tok_r.tap;
      s1_w_r     <= w_rd;
      s1_prod_r  <= tok_r.x * mul_b;
      s2_upd_r   <= s1_vld_r && s1_upd_r;
      s2_tap_r   <= s1_tap_r;
      s2_w_r     <= s1_w_r;
      pp_hi_r    <= $signed(s1_prod_r[2*DW-1:DW]) * $signed({1'b0, mu});
      pp_lo_r    <= s1_prod_r[DW-1:0] * mu;
      if (s1_vld_r && !s1_upd_r) acc_r <= acc_nxt;
      fin_r  <= s1_vld_r && !s1_upd_r && s1_lst_r;
      fin2_r <= fin_r;
      if (fin_r) y_r <= y_sat;
      if (fin2_r) e_r <= sat32(32'(tgt) - 32'(y_r));
      if (s2_upd_r && en) begin
        w_r[s2_tap_r] <= w_new;
      end else if (wl.vld && wl.unit == cell_idx && wl.tap <= TAP_W'(MAX_INPUTS)) begin
        w_r[wl.tap] <= wl.val;
      end
    end
  end
endmodule

@@ hdl/lms_linear_layer_trainer_unit.sv @@
// top level: sample loading, tap sequencer, cell chain and result register
// depends on lmstrn_pkg, lmstrn_if and lmstrn_cell
// input, target and weight beats are accepted only in the idle state
// the final target starts a tap pass over the bias and every input in use, then a drain,
// then one result per unit, which backpressure can stall,
// then with training on a second tap pass and drain that apply the weight updates
// reset is synchronous active low: control and configuration registers to their defaults, weights to zero
`timescale 1ns / 1ps
module lms_linear_layer_trainer_unit
  import lmstrn_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  lmstrn_in_if.sink    in_bus,
  lmstrn_out_if.source out_bus,
  lmstrn_cfg_if.sink   cfg_bus
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_MDRAIN, ST_EMIT, ST_UPD, ST_UDRAIN
  } state_t;

  state_t               state_r;
  logic [MU_W-1:0]      mu_r;
  logic signed [DW-1:0] bias_r;
  logic [TAP_W-1:0]     ninp_r;
  logic [2:0]           nunits_r;
  logic                 train_r;
  logic [TAP_W-1:0]     pos_r;
  logic signed [DW-1:0] xin_r [MAX_INPUTS];
  logic signed [DW-1:0] tgt_r [MAX_UNITS];
  logic [TAP_W-1:0]     cnt_r;
  logic [DRN_W-1:0]     drain_r;
  logic [2:0]           ounit_r;
  tok_t                 issue_r;
  logic                 out_valid_r;
  logic [UNIT_W-1:0]    out_unit_r;
  logic signed [DW-1:0] out_y_r, out_e_r;
  logic                 out_last_r;
  tok_t                 chain [MAX_UNITS+1];
  cell_res_t            res [MAX_UNITS];
  wload_t               wl;
  logic                 in_acc;
  logic [TAP_W-1:0]     tidx;
  logic [TAP_W-1:0]     cfg_ninp;
  logic [2:0]           cfg_nunits;
  tok_t                 tok_nxt;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign tidx          = pos_r - ninp_r;

  assign wl.vld  = in_acc && in_bus.kind == KIND_WLOAD;
  assign wl.unit = in_bus.unit;
  assign wl.tap  = in_bus.tap;
  assign wl.val  = in_bus.value;

  assign cfg_ninp   = (cfg_bus.data[4:0] == '0) ? TAP_W'(1) :
                      (cfg_bus.data[4:0] > TAP_W'(MAX_INPUTS)) ? TAP_W'(MAX_INPUTS) :
                      cfg_bus.data[4:0];
  assign cfg_nunits = (cfg_bus.data[2:0] == '0) ? 3'd1 :
                      (cfg_bus.data[2:0] > 3'(MAX_UNITS)) ? 3'(MAX_UNITS) :
                      cfg_bus.data[2:0];

  always_comb begin
    tok_nxt.vld = 1'b1;
    tok_nxt.upd = (state_r == ST_UPD);
    tok_nxt.lst = (cnt_r == ninp_r);
    tok_nxt.tap = cnt_r;
    tok_nxt.x   = (cnt_r == '0) ? bias_r : xin_r[XIDX_W'(cnt_r - TAP_W'(1))];
  end

  assign chain[0] = issue_r;
  for (genvar k = 0; k < MAX_UNITS; k++) begin : g_cell
    lmstrn_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (UNIT_W'(k)),
      .en       (3'(k) < nunits_r),
      .mu       (mu_r),
      .tgt      (tgt_r[k]),
      .wl       (wl),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1]),
      .res_o    (res[k])
    );
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.unit_index  = out_unit_r;
  assign out_bus.unit_output = out_y_r;
  assign out_bus.unit_error  = out_e_r;
  assign out_bus.last        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mu_r        <= MU_W'(655);
      bias_r      <= DW'(1048576);
      ninp_r      <= TAP_W'(MAX_INPUTS);
      nunits_r    <= 3'(MAX_UNITS);
      train_r     <= 1'b1;
      pos_r       <= '0;
      cnt_r       <= '0;
      drain_r     <= '0;
      ounit_r     <= '0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      issue_r <= '0;
      if (out_valid_r && out_bus.ready) out_valid_r <= 1'b0;
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          CFG_STEP:   mu_r <= cfg_bus.data[MU_W-1:0];
          CFG_BIAS:   bias_r <= cfg_bus.data;
          CFG_NINP: begin
            ninp_r <= cfg_ninp;
            pos_r  <= '0;
          end
          CFG_NUNITS: begin
            nunits_r <= cfg_nunits;
            pos_r    <= '0;
          end
          CFG_TRAIN:  train_r <= cfg_bus.data[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_bus.kind)
              KIND_INPUT: begin
                if (pos_r < ninp_r) begin
                  xin_r[pos_r[XIDX_W-1:0]] <= in_bus.value;
                  pos_r <= pos_r + TAP_W'(1);
                end
              end
              KIND_TARGET: begin
                if (pos_r >= ninp_r) begin
                  if (tidx >= TAP_W'(nunits_r)) begin
                    pos_r <= '0;
                  end else begin
                    tgt_r[tidx[UNIT_W-1:0]] <= in_bus.value;
                    if (tidx + TAP_W'(1) == TAP_W'(nunits_r)) begin
                      pos_r   <= '0;
                      cnt_r   <= '0;
                      state_r <= ST_MAC;
                    end else begin
                      pos_r <= pos_r + TAP_W'(1);
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_MAC, ST_UPD: begin
          issue_r <= tok_nxt;
          cnt_r   <= cnt_r + TAP_W'(1);
          if (cnt_r == ninp_r) begin
            drain_r <= DRN_W'(DRAIN_CYC);
            state_r <= (state_r == ST_MAC) ? ST_MDRAIN : ST_UDRAIN;
          end
        end
        ST_MDRAIN: begin
          drain_r <= drain_r - DRN_W'(1);
          if (drain_r == '0) begin
            ounit_r <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_unit_r  <= ounit_r[UNIT_W-1:0];
            out_y_r     <= res[ounit_r[UNIT_W-1:0]].y;
            out_e_r     <= res[ounit_r[UNIT_W-1:0]].e;
            out_last_r  <= (ounit_r + 3'd1 == nunits_r);
            ounit_r     <= ounit_r + 3'd1;
            if (ounit_r + 3'd1 == nunits_r) begin
              cnt_r   <= '0;
              state_r <= train_r ? ST_UPD : ST_IDLE;
            end
          end
        end
        ST_UDRAIN: begin
          drain_r <= drain_r - DRN_W'(1);
          if (drain_r == '0) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (3'(out_unit_r) + 3'd1 == nunits_r)))
    else $error("last flag does not match final unit");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ninp_r + TAP_W'(nunits_r))
    else $error("load position past sample length");
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC || state_r == ST_UPD) |-> cnt_r <= ninp_r)
    else $error("tap counter past input count");
  a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> ounit_r < nunits_r)
    else $error("result unit counter overrun");
`endif
endmodule

@@ test/lms_linear_layer_trainer_unit_tb.sv @@
// self-checking testbench for the lms linear layer trainer: directed table, then random samples
// checks every result beat against an in-bench predictor of outputs, errors and weight updates
// depends on lmstrn_pkg, lmstrn_if and the trainer top level
`timescale 1ns / 1ps
module lms_linear_layer_trainer_unit_tb;
  import lmstrn_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int SETTLE_CYC = 80;
  localparam longint Q_HI = 64'sd8388607;
  localparam longint Q_LO = -64'sd8388608;

  typedef struct {
    logic [UNIT_W-1:0]    unit;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] e;
    logic                 last;
  } unit_res_t;

  typedef struct {
    logic [1:0]           k;
    logic signed [DW-1:0] v;
    logic [UNIT_W-1:0]    un;
    logic [TAP_W-1:0]     tp;
    bit                   has_exp;
    logic signed [DW-1:0] ey;
    logic signed [DW-1:0] ee;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   errors;
  bit   calm;
  bit   hold_req;

  unit_res_t pending_res_q[$];

  longint weight_mem[MAX_UNITS*ROW_LEN];
  longint sample_vec[MAX_INPUTS];
  longint target_vec[MAX_UNITS];
  int     fill_pos;
  longint mu_val;
  longint bias_val;
  int     n_inputs;
  int     n_units;
  bit     train_on;

  lmstrn_in_if  in_bus();
  lmstrn_out_if out_bus();
  lmstrn_cfg_if cfg_bus();

  lms_linear_layer_trainer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint sat_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic longint step_delta(longint err, longint x);
    longint p;
    p = 2 * mu_val * err * x;
    return (p + (longint'(1) <<< 35)) >>> 36;
  endfunction

  function automatic int clamp_cnt(int v, int mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic lms_predict(logic [1:0] k, logic signed [DW-1:0] v, logic [UNIT_W-1:0] un,
                             logic [TAP_W-1:0] tp);
    int        i;
    int        u;
    int        base;
    longint    acc;
    longint    y;
    longint    e;
    unit_res_t r;
    case (k)
      KIND_WLOAD: begin
        if (tp <= MAX_INPUTS) weight_mem[un*ROW_LEN + tp] = v;
      end
      KIND_INPUT: begin
        if (fill_pos < n_inputs) begin
          sample_vec[fill_pos] = v;
          fill_pos++;
        end
      end
      KIND_TARGET: begin
        if (fill_pos >= n_inputs) begin
          i = fill_pos - n_inputs;
          if (i >= n_units) begin
            fill_pos = 0;
          end else begin
            target_vec[i] = v;
            fill_pos++;
            if (i + 1 == n_units) begin
              fill_pos = 0;
              for (u = 0; u < n_units; u++) begin
                base = u * ROW_LEN;
                acc = bias_val * weight_mem[base];
                for (i = 0; i < n_inputs; i++) acc += sample_vec[i] * weight_mem[base+i+1];
                y = sat_q((acc + (longint'(1) <<< 19)) >>> 20);
                e = sat_q(target_vec[u] - y);
                if (train_on) begin
                  weight_mem[base] = sat_q(weight_mem[base] + step_delta(e, bias_val));
                  for (i = 0; i < n_inputs; i++)
                    weight_mem[base+i+1] = sat_q(weight_mem[base+i+1] +
                                                 step_delta(e, sample_vec[i]));
                end
                r.unit = u[UNIT_W-1:0];
                r.y    = y[DW-1:0];
                r.e    = e[DW-1:0];
                r.last = (u + 1 == n_units);
                pending_res_q.push_back(r);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DW-1:0] d);
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_res_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = d;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_STEP:   mu_val = d[15:0];
      CFG_BIAS:   bias_val = $signed(d);
      CFG_NINP:   begin n_inputs = clamp_cnt(d[4:0], MAX_INPUTS); fill_pos = 0; end
      CFG_NUNITS: begin n_units = clamp_cnt(d[2:0], MAX_UNITS); fill_pos = 0; end
      CFG_TRAIN:  train_on = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_beat(stim_row_t s);
    int n;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.kind  = s.k;
    in_bus.value = s.v;
    in_bus.unit  = s.un;
    in_bus.tap   = s.tp;
    do @(posedge clk); while (!in_bus.ready);
    n = pending_res_q.size();
    lms_predict(s.k, s.v, s.un, s.tp);
    if (s.has_exp && pending_res_q.size() > n) begin
      pending_res_q[n].y = s.ey;
      pending_res_q[n].e = s.ee;
    end
  endtask

  function automatic logic signed [DW-1:0] rand_val();
    logic signed [DW-1:0] v;
    if ($urandom_range(0, 3) == 0) v = DW'($urandom);
    else v = DW'($signed($urandom_range(0, 4194303)) - 32'sd2097152);
    return v;
  endfunction

  function automatic stim_row_t beat(logic [1:0] k, logic signed [DW-1:0] v,
                                     logic [UNIT_W-1:0] un = '0, logic [TAP_W-1:0] tp = '0);
    stim_row_t s;
    s = '{k, v, un, tp, 1'b0, '0, '0};
    return s;
  endfunction

  task automatic run_phase(logic [DW-1:0] mu, logic [DW-1:0] bs, logic [DW-1:0] ni,
                           logic [DW-1:0] nu, bit tr, int nsamp, bit quiet, bit hold);
    int s;
    int j;
    write_reg(CFG_STEP, mu);
    write_reg(CFG_BIAS, bs);
    write_reg(CFG_NINP, ni);
    write_reg(CFG_NUNITS, nu);
    write_reg(CFG_TRAIN, DW'(tr));
    calm = quiet;
    if (hold) hold_req = 1'b1;
    for (s = 0; s < nsamp; s++) begin
      for (j = 0; j < n_inputs + n_units; j++) begin
        case ($urandom_range(0, 19))
          0: send_beat(beat(KIND_WLOAD, rand_val(), UNIT_W'($urandom), TAP_W'($urandom)));
          1: send_beat(beat(KIND_NONE, rand_val(), UNIT_W'($urandom), TAP_W'($urandom)));
          2: send_beat(beat(j < n_inputs ? KIND_TARGET : KIND_INPUT, rand_val()));
          default: ;
        endcase
        send_beat(beat(j < n_inputs ? KIND_INPUT : KIND_TARGET, rand_val()));
      end
    end
    // partial sample left behind, cleared by the next size write
    send_beat(beat(KIND_INPUT, rand_val()));
    calm = 1'b0;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_bus.ready = calm || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin
    unit_res_t x;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_res_q.size() == 0) begin
        report($sformatf("unexpected result beat unit %0d", out_bus.unit_index));
      end else begin
        x = pending_res_q.pop_front();
        if (out_bus.unit_index !== x.unit)
          report($sformatf("unit_index %0d, want %0d", out_bus.unit_index, x.unit));
        if (out_bus.unit_output !== x.y)
          report($sformatf("unit_output %0d, want %0d", out_bus.unit_output, x.y));
        if (out_bus.unit_error !== x.e)
          report($sformatf("unit_error %0d, want %0d", out_bus.unit_error, x.e));
        if (out_bus.last !== x.last)
          report($sformatf("last %0b, want %0b", out_bus.last, x.last));
      end
    end
  end

  stim_row_t dir_tab[$];

  initial begin
    int r;
    errors   = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    rst_n    = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_INPUT;
    in_bus.value  = '0;
    in_bus.unit   = '0;
    in_bus.tap    = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_STEP;
    cfg_bus.data  = '0;
    foreach (weight_mem[i]) weight_mem[i] = 0;
    foreach (sample_vec[i]) sample_vec[i] = 0;
    foreach (target_vec[i]) target_vec[i] = 0;
    fill_pos = 0;
    mu_val   = 655;
    bias_val = 1048576;
    n_inputs = 16;
    n_units  = 4;
    train_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_tab.push_back(beat(KIND_INPUT, 24'sh7fffff));
    dir_tab.push_back('{KIND_TARGET, -24'sd8388608, 0, 0, 1'b1, 24'sd0, -24'sd8388608});
    dir_tab.push_back(beat(KIND_TARGET, 24'sd0));
    dir_tab.push_back(beat(KIND_NONE, -24'sd1, 2'd3, 5'd31));
    dir_tab.push_back(beat(KIND_WLOAD, 24'sh7fffff, 2'd0, 5'd0));
    dir_tab.push_back(beat(KIND_WLOAD, -24'sd8388608, 2'd0, 5'd1));
    dir_tab.push_back(beat(KIND_WLOAD, 24'sd123, 2'd3, 5'd16));
    dir_tab.push_back(beat(KIND_WLOAD, 24'sd77, 2'd1, 5'd17));
    dir_tab.push_back(beat(KIND_WLOAD, 24'sd99, 2'd2, 5'd31));
    dir_tab.push_back(beat(KIND_INPUT, -24'sd8388608));
    dir_tab.push_back(beat(KIND_INPUT, 24'sd5));
    dir_tab.push_back(beat(KIND_WLOAD, -24'sd8388608, 2'd0, 5'd1));
    dir_tab.push_back(beat(KIND_TARGET, 24'sh7fffff));
    dir_tab.push_back(beat(KIND_INPUT, 24'sh7fffff));
    dir_tab.push_back(beat(KIND_TARGET, -24'sd8388608));
    dir_tab.push_back(beat(KIND_INPUT, -24'sd8388608));
    dir_tab.push_back(beat(KIND_TARGET, 24'sh7fffff));
    dir_tab.push_back(beat(KIND_INPUT, 24'sd0));
    dir_tab.push_back(beat(KIND_TARGET, 24'sd0));

    write_reg(CFG_UNUSED, 24'hffffff);
    write_reg(CFG_STEP, 24'hffff);
    write_reg(CFG_BIAS, 24'h7fffff);
    write_reg(CFG_NINP, 24'd1);
    write_reg(CFG_NUNITS, 24'd1);
    write_reg(CFG_TRAIN, 24'd0);
    for (r = 0; r < dir_tab.size(); r++) begin
      if (r == 13) write_reg(CFG_TRAIN, 24'd1);
      send_beat(dir_tab[r]);
    end

    run_phase(24'hffff, 24'h7fffff, 24'd16, 24'd4, 1'b1, 1, 1'b0, 1'b1);
    run_phase(24'h0, 24'h800000, 24'd0, 24'd0, 1'b1, 3, 1'b0, 1'b0);
    run_phase(DW'($urandom), DW'($urandom), 24'd3, 24'd2, 1'b1, 3, 1'b1, 1'b0);
    run_phase(DW'($urandom), DW'($urandom), 24'd2, 24'd3, 1'b1, 2, 1'b0, 1'b0);
    run_phase(DW'($urandom), DW'($urandom), 24'd31, 24'd7, 1'b0, 1, 1'b0, 1'b0);

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
